>>> rtl/core/chord_length_histogram_unit_defines.svh
// assertion macros for the chord length histogram unit
`ifndef CHORD_LENGTH_HISTOGRAM_UNIT_DEFINES_SVH
`define CHORD_LENGTH_HISTOGRAM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define CLH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CLH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CLH_ASSERT_NOW(lbl, ante, cons, msg)
`define CLH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/clh_pkg.sv
`timescale 1ns / 1ps
package clh_pkg;

    localparam int unsigned DEF_MAX_CHORD  = 1024;
    localparam int unsigned DEF_COUNT_BITS = 32;

    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned AXIS_W    = 2;
    localparam int unsigned BIN_IDX_W = 10;
    localparam int unsigned OUT_W     = 32;

    localparam logic REQ_VOXEL = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic valid;
        logic is_read;
        logic drop;
    } hist_op_t;

    typedef struct packed {
        logic clearing;
        logic rd_inflight;
    } hist_status_t;

endpackage

>>> rtl/core/clh_line_tracker.sv
`timescale 1ns / 1ps
module clh_line_tracker #(
    parameter int unsigned MAX_CHORD = clh_pkg::DEF_MAX_CHORD,
    localparam int unsigned BIN_W    = $clog2(MAX_CHORD)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic                          s_is_pore,
    input  logic                          s_line_end,
    input  logic [clh_pkg::AXIS_W-1:0]    s_axis,
    input  logic [clh_pkg::BIN_IDX_W-1:0] s_bin_index,
    input  logic                          clearing,
    input  logic                          rd_room,
    output clh_pkg::hist_op_t             op,
    output logic [clh_pkg::AXIS_W-1:0]    op_axis,
    output logic [BIN_W-1:0]              op_bin
);
    import clh_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_CHORD + 1);
    localparam logic [LEN_W:0]   MAX_EXT = (LEN_W + 1)'(MAX_CHORD);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHORD);

    logic [LEN_W-1:0]  run_length_reg, run_length_next;
    logic [LEN_W-1:0]  held_first_chord_reg, held_first_chord_next;
    logic              held_valid_reg, held_valid_next;
    logic              line_started_pore_reg, line_started_pore_next;
    logic              at_line_start_reg, at_line_start_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AXIS_W-1:0] pend_axis_reg, pend_axis_next;
    logic [BIN_W-1:0]  pend_bin_reg, pend_bin_next;

    logic             voxel_acc, rd_acc, axis_ok, bin_ok, lsp_eff;
    logic [LEN_W:0]   run_inc, merge_sum;
    logic [LEN_W-1:0] run_sat, merge_sat;
    logic [LEN_W-1:0] run_mid, held_mid;
    logic             hv_mid;
    logic             w_v, e1_v, e2_v;
    logic [LEN_W-1:0] w_len, e1_len, e2_len;
    logic             first_v, second_v;
    logic [LEN_W-1:0] first_len, second_len;

    assign s_ready   = !clearing && !pend_valid_reg && (s_req_type == REQ_VOXEL || rd_room);
    assign voxel_acc = s_valid && s_ready && s_req_type == REQ_VOXEL;
    assign rd_acc    = s_valid && s_ready && s_req_type == REQ_READ;
    assign axis_ok   = s_axis < AXIS_W'(NUM_AXES);
    assign bin_ok    = 32'(s_bin_index) < 32'(MAX_CHORD);

    always_comb begin
        lsp_eff  = at_line_start_reg ? s_is_pore : line_started_pore_reg;
        run_inc  = {1'b0, run_length_reg} + (LEN_W + 1)'(1);
        run_sat  = (run_inc > MAX_EXT) ? MAX_LEN : run_inc[LEN_W-1:0];
        run_mid  = run_length_reg;
        held_mid = held_first_chord_reg;
        hv_mid   = held_valid_reg;
        w_v      = 1'b0;
        w_len    = run_length_reg;

        // wall voxel closes the run in progress
        if (s_is_pore) begin
            run_mid = run_sat;
        end else if (run_length_reg != '0) begin
            if (!held_valid_reg) begin
                held_mid = run_length_reg;
                hv_mid   = 1'b1;
            end else begin
                w_v = 1'b1;
            end
            run_mid = '0;
        end

        merge_sum = {1'b0, held_mid} + {1'b0, run_mid};
        merge_sat = (merge_sum > MAX_EXT) ? MAX_LEN : merge_sum[LEN_W-1:0];

        // periodic wrap at the line end
        e1_v   = 1'b0;
        e2_v   = 1'b0;
        e1_len = held_mid;
        e2_len = run_mid;
        if (s_line_end) begin
            if (hv_mid && run_mid != '0 && lsp_eff) begin
                e1_v   = 1'b1;
                e1_len = merge_sat;
            end else begin
                e1_v = hv_mid;
                e2_v = run_mid != '0;
            end
        end

        first_v    = w_v || e1_v || e2_v;
        first_len  = w_v ? w_len : (e1_v ? e1_len : e2_len);
        second_v   = e1_v && (w_v || e2_v);
        second_len = w_v ? e1_len : e2_len;

        run_length_next        = run_length_reg;
        held_first_chord_next  = held_first_chord_reg;
        held_valid_next        = held_valid_reg;
        line_started_pore_next = line_started_pore_reg;
        at_line_start_next     = at_line_start_reg;
        if (voxel_acc) begin
            if (s_line_end) begin
                run_length_next        = '0;
                held_first_chord_next  = '0;
                held_valid_next        = 1'b0;
                line_started_pore_next = 1'b0;
                at_line_start_next     = 1'b1;
            end else begin
                run_length_next        = run_mid;
                held_first_chord_next  = held_mid;
                held_valid_next        = hv_mid;
                line_started_pore_next = lsp_eff;
                at_line_start_next     = 1'b0;
            end
        end

        pend_valid_next = 1'b0;
        pend_axis_next  = pend_axis_reg;
        pend_bin_next   = pend_bin_reg;
        if (voxel_acc && second_v && axis_ok) begin
            pend_valid_next = 1'b1;
            pend_axis_next  = s_axis;
            pend_bin_next   = BIN_W'(second_len - LEN_W'(1));
        end

        op      = '0;
        op_axis = s_axis;
        op_bin  = BIN_W'(first_len - LEN_W'(1));
        if (pend_valid_reg) begin
            op.valid = 1'b1;
            op_axis  = pend_axis_reg;
            op_bin   = pend_bin_reg;
        end else if (rd_acc) begin
            op.valid   = 1'b1;
            op.is_read = 1'b1;
            op.drop    = !axis_ok || !bin_ok;
            op_bin     = BIN_W'(s_bin_index);
        end else if (voxel_acc && first_v && axis_ok) begin
            op.valid = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_length_reg        <= '0;
            held_first_chord_reg  <= '0;
            held_valid_reg        <= 1'b0;
            line_started_pore_reg <= 1'b0;
            at_line_start_reg     <= 1'b1;
            pend_valid_reg        <= 1'b0;
        end else begin
            run_length_reg        <= run_length_next;
            held_first_chord_reg  <= held_first_chord_next;
            held_valid_reg        <= held_valid_next;
            line_started_pore_reg <= line_started_pore_next;
            at_line_start_reg     <= at_line_start_next;
            pend_valid_reg        <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_axis_reg <= pend_axis_next;
        pend_bin_reg  <= pend_bin_next;
    end

endmodule

>>> rtl/core/clh_hist_mem.sv
`timescale 1ns / 1ps
module clh_hist_mem #(
    parameter int unsigned MAX_CHORD  = clh_pkg::DEF_MAX_CHORD,
    parameter int unsigned COUNT_BITS = clh_pkg::DEF_COUNT_BITS,
    localparam int unsigned BIN_W     = $clog2(MAX_CHORD)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  clh_pkg::hist_op_t          op,
    input  logic [clh_pkg::AXIS_W-1:0] op_axis,
    input  logic [BIN_W-1:0]           op_bin,
    output clh_pkg::hist_status_t      status,
    output logic                       res_valid,
    output logic [clh_pkg::OUT_W-1:0]  res_data
);
    import clh_pkg::*;

    localparam int unsigned DEPTH  = NUM_AXES * MAX_CHORD;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0]     BASE_Y    = ADDR_W'(MAX_CHORD);
    localparam logic [ADDR_W-1:0]     BASE_Z    = ADDR_W'(2 * MAX_CHORD);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic                  clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                  stb_valid_reg;
    logic                  stb_read_reg, stb_drop_reg;
    logic [ADDR_W-1:0]     stb_addr_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  fwd_hit_reg, fwd_hit_next;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic [ADDR_W-1:0]     base, addr;
    logic                  rd_en, inc_we, we;
    logic [ADDR_W-1:0]     waddr;
    logic [COUNT_BITS-1:0] old_count, new_count, wdata;

    always_comb begin
        case (op_axis)
            2'd1:    base = BASE_Y;
            2'd2:    base = BASE_Z;
            default: base = '0;
        endcase
        addr  = base + ADDR_W'(op_bin);
        rd_en = op.valid && !op.drop;

        old_count = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_BITS'(1);
        inc_we    = stb_valid_reg && !stb_read_reg && !stb_drop_reg;

        // write port shared by the clearing pass and the increment stage
        we    = clr_busy_reg || inc_we;
        waddr = clr_busy_reg ? clr_addr_reg : stb_addr_reg;
        wdata = clr_busy_reg ? '0 : new_count;

        // read issued in the same cycle as the write to its entry
        fwd_hit_next = inc_we && rd_en && stb_addr_reg == addr;

        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_next = 1'b0;
            end
        end

        res_valid = stb_valid_reg && stb_read_reg;
        res_data  = stb_drop_reg ? '0 : OUT_W'(old_count);

        status.clearing    = clr_busy_reg;
        status.rd_inflight = res_valid;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            stb_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            stb_valid_reg <= op.valid;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        stb_read_reg <= op.is_read;
        stb_drop_reg <= op.drop;
        stb_addr_reg <= addr;
        fwd_data_reg <= new_count;
    end

endmodule

>>> rtl/core/clh_result_fifo.sv
`timescale 1ns / 1ps
module clh_result_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  logic [clh_pkg::OUT_W-1:0] push_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [clh_pkg::OUT_W-1:0] m_bin_count,
    output logic [1:0]                count
);
    import clh_pkg::*;

    logic [OUT_W-1:0] data_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign m_valid     = count_reg != 2'd0;
    assign m_bin_count = data_reg[rd_ptr_reg];
    assign count       = count_reg;
    assign pop         = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/chord_length_histogram_unit.sv
// read path: a bin count is registered at the memory, then queued in the result FIFO
// throughput: one request per cycle while not clearing and while reads find a result slot;
// two-chord voxels hold s_ready low one cycle, as one write port does one increment a cycle
// reset: aresetn clears the line state, then the histogram is cleared one entry a cycle,
// all 3 * MAX_CHORD entries (3072 by default), with s_ready low throughout
`timescale 1ns / 1ps
`include "chord_length_histogram_unit_defines.svh"
module chord_length_histogram_unit #(
    parameter int unsigned MAX_CHORD  = clh_pkg::DEF_MAX_CHORD,
    parameter int unsigned COUNT_BITS = clh_pkg::DEF_COUNT_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic                          s_is_pore,
    input  logic                          s_line_end,
    input  logic [clh_pkg::AXIS_W-1:0]    s_axis,
    input  logic [clh_pkg::BIN_IDX_W-1:0] s_bin_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [clh_pkg::OUT_W-1:0]     m_bin_count
);
    import clh_pkg::*;

    localparam int unsigned BIN_W = $clog2(MAX_CHORD);

    hist_op_t          op;
    logic [AXIS_W-1:0] op_axis;
    logic [BIN_W-1:0]  op_bin;
    hist_status_t      status;
    logic              res_valid;
    logic [OUT_W-1:0]  res_data;
    logic [1:0]        fifo_count;
    logic [1:0]        occ;
    logic              rd_room;

    // reads in flight plus results waiting must fit the two result slots
    assign occ     = {1'b0, status.rd_inflight} + fifo_count;
    assign rd_room = (occ < 2'd2) || (m_valid && m_ready);

    clh_line_tracker #(
        .MAX_CHORD (MAX_CHORD)
    ) u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_is_pore   (s_is_pore),
        .s_line_end  (s_line_end),
        .s_axis      (s_axis),
        .s_bin_index (s_bin_index),
        .clearing    (status.clearing),
        .rd_room     (rd_room),
        .op          (op),
        .op_axis     (op_axis),
        .op_bin      (op_bin)
    );

    clh_hist_mem #(
        .MAX_CHORD  (MAX_CHORD),
        .COUNT_BITS (COUNT_BITS)
    ) u_hist_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .op_axis   (op_axis),
        .op_bin    (op_bin),
        .status    (status),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    clh_result_fifo u_result_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (res_valid),
        .push_data   (res_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_count (m_bin_count),
        .count       (fifo_count)
    );

    `CLH_ASSERT_NOW(a_no_request_while_clearing, status.clearing, !s_ready, "request taken during clearing pass")
    `CLH_ASSERT_NOW(a_result_slots_bounded, 1'b1, occ != 2'd3, "result slots overrun")
    `CLH_ASSERT_NEXT(a_read_enters_pipe, s_valid && s_ready && s_req_type == REQ_READ, status.rd_inflight, "read request lost")
    `CLH_ASSERT_NOW(a_no_op_while_clearing, status.clearing, !op.valid, "histogram access during clearing pass")

endmodule
